// ===== hw/rtl/heading_and_distance_assert.svh =====
// Assertion helpers for the file that checks the heading and distance block.
// Each macro samples on the rising edge of clk and is switched off while arst_n is low.
`ifndef HEADING_AND_DISTANCE_ASSERT_SVH
`define HEADING_AND_DISTANCE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold a fixed number of cycles after the antecedent.
`define HD_ASSERT_DELAY(label, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/hd_pkg.sv =====
`timescale 1ns / 1ps

package hd_pkg;

	// Field widths.
	localparam int IN_W   = 20;
	localparam int DIFF_W = IN_W + 1;
	localparam int HEAD_W = 19;
	localparam int DIST_W = 21;
	localparam int THR_W  = 16;

	// Square root: one result bit per stage over the sum of squares.
	localparam int SQ_W       = 2 * DIFF_W;
	localparam int SQRT_STEPS = SQ_W / 2;
	localparam int SQRT_TOP   = SQ_W - 2;

	// CORDIC datapath: guard bits below the differences, angle in 2^-32 rad.
	localparam int CORDIC_STEPS     = 20;
	localparam int CORDIC_MAX_STEPS = 30;
	localparam int GUARD            = 8;
	localparam int CW               = 32;
	localparam int ZW               = 36;
	localparam int ANG_FRAC         = 16;
	localparam int QW               = ZW - ANG_FRAC;

	// Pipeline depth.
	localparam int PIPE_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
	localparam int FRONT_STAGES = 3;
	localparam int BACK_STAGES  = 2;
	localparam int LATENCY      = FRONT_STAGES + PIPE_STEPS + BACK_STAGES;

	// Constants.
	localparam logic [THR_W-1:0]      THR_RESET = THR_W'(7);
	localparam logic signed [ZW-1:0]  PI_Q32    = 36'sd13493037704;
	localparam logic signed [ZW-1:0]  HALF_LSB  = ZW'(32768);
	localparam logic signed [QW-1:0]  Q_PI      = QW'(205887);
	localparam logic signed [QW-1:0]  Q_PI_MAX  = QW'(205886);
	localparam logic signed [QW-1:0]  Q_PI_NEG  = -Q_PI;
	localparam logic signed [HEAD_W-1:0] HEAD_MIN = -19'sd205887;
	localparam logic signed [HEAD_W-1:0] HEAD_MAX = 19'sd205886;
	localparam logic [DIST_W-1:0]     DIST_MAX  = DIST_W'(1482910);

	// atan(2^-i) in units of 2^-32 rad, rounded to nearest.
	localparam logic signed [ZW-1:0] CORDIC_ANGLE [CORDIC_MAX_STEPS] = '{
		36'sd3373259426, 36'sd1991351318, 36'sd1052175346, 36'sd534100635,
		36'sd268086748,  36'sd134174063,  36'sd67103403,   36'sd33553749,
		36'sd16777131,   36'sd8388597,    36'sd4194303,    36'sd2097152,
		36'sd1048576,    36'sd524288,     36'sd262144,     36'sd131072,
		36'sd65536,      36'sd32768,      36'sd16384,      36'sd8192,
		36'sd4096,       36'sd2048,       36'sd1024,       36'sd512,
		36'sd256,        36'sd128,        36'sd64,         36'sd32,
		36'sd16,         36'sd8
	};

	// Work carried through the iteration stages.
	typedef struct packed {
		logic [SQ_W-1:0]        rem;
		logic [SQ_W-1:0]        root;
		logic signed [CW-1:0]   x;
		logic signed [CW-1:0]   y;
		logic signed [ZW-1:0]   z;
		logic                   neg_axis;
	} hd_work_t;

endpackage

// ===== hw/rtl/hd_front.sv =====
`timescale 1ns / 1ps

module hd_front
	import hd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic signed [IN_W-1:0]   from_x,
	input  logic signed [IN_W-1:0]   from_y,
	input  logic signed [IN_W-1:0]   to_x,
	input  logic signed [IN_W-1:0]   to_y,
	output logic                     out_valid,
	output hd_work_t                 out_work
);

	logic                      valid_s1, valid_s2, valid_s3;
	logic signed [DIFF_W-1:0]  dx_s1, dy_s1;
	logic [SQ_W-1:0]           sqx_s2, sqy_s2;
	logic signed [CW-1:0]      x0_s2, y0_s2;
	logic signed [ZW-1:0]      z0_s2;
	logic                      neg_axis_s2;
	hd_work_t                  work_s3;

	logic signed [DIFF_W-1:0]  dx_c, dy_c;
	logic signed [SQ_W-1:0]    sqx_c, sqy_c;
	logic                      neg_x;
	logic signed [DIFF_W-1:0]  ax_c, ay_c;
	logic signed [ZW-1:0]      z0_c;
	hd_work_t                  work_c;

	// Valid bits of the three front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1: exact differences of the two positions.
	assign dx_c = $signed({to_x[IN_W-1], to_x}) - $signed({from_x[IN_W-1], from_x});
	assign dy_c = $signed({to_y[IN_W-1], to_y}) - $signed({from_y[IN_W-1], from_y});

	always_ff @(posedge clk) begin
		if (in_valid) begin
			dx_s1 <= dx_c;
			dy_s1 <= dy_c;
		end
	end

	// Stage 2: squares, and the vector folded into the right half plane.
	assign sqx_c = dx_s1 * dx_s1;
	assign sqy_c = dy_s1 * dy_s1;
	assign neg_x = dx_s1[DIFF_W-1];
	assign ax_c  = neg_x ? -dx_s1 : dx_s1;
	assign ay_c  = neg_x ? -dy_s1 : dy_s1;

	// A folded vector starts its angle at plus or minus pi, or at zero on the negative x axis.
	always_comb begin
		priority if (neg_x && !dy_s1[DIFF_W-1] && (dy_s1 != '0)) begin
			z0_c = PI_Q32;
		end else if (neg_x && dy_s1[DIFF_W-1]) begin
			z0_c = -PI_Q32;
		end else begin
			z0_c = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			sqx_s2      <= sqx_c;
			sqy_s2      <= sqy_c;
			x0_s2       <= CW'(ax_c) <<< GUARD;
			y0_s2       <= CW'(ay_c) <<< GUARD;
			z0_s2       <= z0_c;
			neg_axis_s2 <= neg_x && (dy_s1 == '0);
		end
	end

	// Stage 3: sum of squares seeds the square root.
	assign work_c = '{
		rem:      sqx_s2 + sqy_s2,
		root:     '0,
		x:        x0_s2,
		y:        y0_s2,
		z:        z0_s2,
		neg_axis: neg_axis_s2
	};

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			work_s3 <= work_c;
		end
	end

	assign out_valid = valid_s3;
	assign out_work  = work_s3;

endmodule

// ===== hw/rtl/hd_iter.sv =====
`timescale 1ns / 1ps

module hd_iter
	import hd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  hd_work_t  in_work,
	output logic      out_valid,
	output hd_work_t  out_work
);

	// One register stage per iteration; index i is the i-th iteration.
	logic      valid_si [PIPE_STEPS];
	hd_work_t  work_si  [PIPE_STEPS];

	for (genvar i = 0; i < PIPE_STEPS; i++) begin : g_stage
		hd_work_t              cur;
		logic                  cur_valid;
		logic [SQ_W-1:0]       rem_n, root_n;
		logic signed [CW-1:0]  x_n, y_n;
		logic signed [ZW-1:0]  z_n;

		if (i == 0) begin : g_first
			assign cur       = in_work;
			assign cur_valid = in_valid;
		end else begin : g_next
			assign cur       = work_si[i-1];
			assign cur_valid = valid_si[i-1];
		end

		// One bit of the integer square root.
		if (i < SQRT_STEPS) begin : g_sqrt
			localparam logic [SQ_W-1:0] ONE_BIT = SQ_W'(1) << (SQRT_TOP - 2 * i);
			logic [SQ_W-1:0] trial;

			assign trial = cur.root + ONE_BIT;

			always_comb begin
				if (cur.rem >= trial) begin
					rem_n  = cur.rem - trial;
					root_n = (cur.root >> 1) + ONE_BIT;
				end else begin
					rem_n  = cur.rem;
					root_n = cur.root >> 1;
				end
			end
		end else begin : g_sqrt_hold
			assign rem_n  = cur.rem;
			assign root_n = cur.root;
		end

		// One vectoring rotation, driving y towards zero.
		if (i < CORDIC_STEPS) begin : g_cordic
			logic signed [CW-1:0] xc, yc, xs, ys;

			assign xc = cur.x;
			assign yc = cur.y;
			assign xs = xc >>> i;
			assign ys = yc >>> i;

			always_comb begin
				if (!yc[CW-1]) begin
					x_n = xc + ys;
					y_n = yc - xs;
					z_n = cur.z + CORDIC_ANGLE[i];
				end else begin
					x_n = xc - ys;
					y_n = yc + xs;
					z_n = cur.z - CORDIC_ANGLE[i];
				end
			end
		end else begin : g_cordic_hold
			assign x_n = cur.x;
			assign y_n = cur.y;
			assign z_n = cur.z;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_si[i] <= 1'b0;
			end else begin
				valid_si[i] <= cur_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (cur_valid) begin
				work_si[i] <= '{
					rem:      rem_n,
					root:     root_n,
					x:        x_n,
					y:        y_n,
					z:        z_n,
					neg_axis: cur.neg_axis
				};
			end
		end
	end

	assign out_valid = valid_si[PIPE_STEPS-1];
	assign out_work  = work_si[PIPE_STEPS-1];

endmodule

// ===== hw/rtl/hd_back.sv =====
`timescale 1ns / 1ps

module hd_back
	import hd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  hd_work_t                 in_work,
	input  logic [THR_W-1:0]         thresh,
	output logic                     out_valid,
	output logic signed [HEAD_W-1:0] heading,
	output logic [DIST_W-1:0]        distance,
	output logic                     coincident
);

	logic                      valid_s1, valid_s2;
	logic [DIST_W-1:0]         dist_s1, dist_s2;
	logic signed [QW-1:0]      ang_s1;
	logic signed [HEAD_W-1:0]  head_s2;
	logic                      coin_s2;

	logic [DIST_W-1:0]         root_c, dist_c;
	logic                      round_up;
	logic signed [ZW-1:0]      z_c, v_c;
	logic signed [QW-1:0]      q_c, ang_c;
	logic                      coin_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// Stage 1: round the root to nearest, using the remainder left by the iterations.
	assign root_c   = in_work.root[DIST_W-1:0];
	assign round_up = in_work.rem > in_work.root;
	assign dist_c   = root_c + DIST_W'(round_up);

	// Round the angle to 2^-16 rad and hold it inside [-pi, pi).
	assign z_c = in_work.z;
	assign v_c = z_c + HALF_LSB;
	assign q_c = v_c[ZW-1:ANG_FRAC];

	always_comb begin
		priority if (in_work.neg_axis) begin
			ang_c = Q_PI_NEG;
		end else if (q_c > Q_PI_MAX) begin
			ang_c = Q_PI_MAX;
		end else if (q_c < Q_PI_NEG) begin
			ang_c = Q_PI_NEG;
		end else begin
			ang_c = q_c;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			dist_s1 <= dist_c;
			ang_s1  <= ang_c;
		end
	end

	// Stage 2: coincidence test; a coincident pair reports a zero heading.
	assign coin_c = dist_s1 <= DIST_W'(thresh);

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			dist_s2 <= dist_s1;
			coin_s2 <= coin_c;
			head_s2 <= coin_c ? '0 : ang_s1[HEAD_W-1:0];
		end
	end

	assign out_valid  = valid_s2;
	assign heading    = head_s2;
	assign distance   = dist_s2;
	assign coincident = coin_s2;

endmodule

// ===== hw/rtl/heading_and_distance.sv =====
// Heading and distance between a start and a target position in the plane.
// Command channel: an item is taken at a rising edge where start is high and busy
// is low. busy stays low, so a new position pair may be issued on every cycle.
// Each item gives one result on heading, distance and coincident, marked by done
// for exactly one cycle, once the transfer has passed through 3 front stages,
// 21 square-root/CORDIC stages and 2 rounding/coincidence stages. Throughput is one item per
// cycle. The depth is set by the square root, which yields one root bit per
// stage over the 42-bit sum of squares; the 20 CORDIC rotations share its stages.
// The receiver cannot hold results off, and nothing here needs it to: results
// leave in issue order, one per cycle at most.
// The threshold register is written over cfg_valid / cfg_ready / cfg_data; ready
// is always high. Write it only while no item is in flight.
// Reset (arst_n low) clears every pipeline valid bit, so items in flight are
// dropped and no done follows; the threshold returns to 7.
`timescale 1ns / 1ps
`include "heading_and_distance_assert.svh"

module heading_and_distance
	import hd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [IN_W-1:0]   from_x,
	input  logic signed [IN_W-1:0]   from_y,
	input  logic signed [IN_W-1:0]   to_x,
	input  logic signed [IN_W-1:0]   to_y,
	output logic                     done,
	output logic signed [HEAD_W-1:0] heading,
	output logic [DIST_W-1:0]        distance,
	output logic                     coincident,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [THR_W-1:0]         cfg_data
);

	logic [THR_W-1:0]  thresh_q;
	logic              accept;
	logic              front_valid, iter_valid;
	hd_work_t          front_work, iter_work;

	// The pipeline never stalls, so both channels are always open.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Coincidence threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= cfg_data;
		end
	end

	hd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y),
		.out_valid (front_valid),
		.out_work  (front_work)
	);

	hd_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_work   (front_work),
		.out_valid (iter_valid),
		.out_work  (iter_work)
	);

	hd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (iter_valid),
		.in_work    (iter_work),
		.thresh     (thresh_q),
		.out_valid  (done),
		.heading    (heading),
		.distance   (distance),
		.coincident (coincident)
	);

	// Every transfer comes out as a result once it has passed the whole pipeline.
	`HD_ASSERT_DELAY(a_latency, accept, LATENCY, done, "result missing after pipeline latency")
	// A coincident result always reports a zero heading.
	`HD_ASSERT_IMPL(a_coin_heading, done && coincident, heading == '0, "heading not zero when coincident")
	// The heading stays inside [-pi, pi).
	`HD_ASSERT_IMPL(a_head_range, done, (heading >= HEAD_MIN) && (heading <= HEAD_MAX), "heading out of range")
	// The distance never exceeds the diagonal of the position range.
	`HD_ASSERT_IMPL(a_dist_range, done, distance <= DIST_MAX, "distance out of range")

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import hd_pkg::*;

	// Arithmetic of the heading computation, kept apart from the block's own constants.
	localparam int     ROT_STEPS        = 20;
	localparam int     GUARD_BITS       = 8;
	localparam longint ANGLE_PI         = 64'sd13493037704;
	localparam longint ANGLE_QUARTER_PI = 64'sd3373259426;
	localparam longint HEADING_PI       = 64'sd205887;
	localparam int     IN_MIN           = -524288;
	localparam int     IN_MAX           = 524287;

	// Run shape.
	localparam int DRAIN_CYCLES = 32;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 215;
	localparam int PROBES       = 25;

	// One result of the block.
	typedef struct packed {
		logic signed [HEAD_W-1:0] heading;
		logic [DIST_W-1:0]        distance;
		logic                     coincident;
	} fix_t;

	// One row of the directed table; fix is only meaningful where typed is set.
	typedef struct packed {
		int   fx;
		int   fy;
		int   tx;
		int   ty;
		bit   typed;
		fix_t fix;
	} probe_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     start      = 1'b0;
	logic                     busy;
	logic signed [IN_W-1:0]   from_x     = '0;
	logic signed [IN_W-1:0]   from_y     = '0;
	logic signed [IN_W-1:0]   to_x       = '0;
	logic signed [IN_W-1:0]   to_y       = '0;
	logic                     done;
	logic signed [HEAD_W-1:0] heading;
	logic [DIST_W-1:0]        distance;
	logic                     coincident;
	logic                     cfg_valid  = 1'b0;
	logic                     cfg_ready;
	logic [THR_W-1:0]         cfg_data   = '0;

	// Fixes predicted for position pairs already taken, oldest first.
	fix_t   fixes_in_flight [$];
	logic [THR_W-1:0] threshold_now = 16'd7;
	longint atan_step [ROT_STEPS];
	int     mismatches   = 0;
	int     stall_cycles = 0;
	bit     no_gaps      = 1'b0;

	// A typed-in result travels with its item so the monitor can pick it up at the transfer.
	bit     typed_valid = 1'b0;
	fix_t   typed_fix   = '0;

	// Directed table: coincidence at and around the reset threshold, both axes,
	// the negative x axis, corners of the field range and the wrap near +/-PI.
	probe_t probes [PROBES] = '{
		'{0, 0, 0, 0, 1'b1, '{19'sd0, 21'd0, 1'b1}},
		'{-524288, -524288, -524288, -524288, 1'b1, '{19'sd0, 21'd0, 1'b1}},
		'{524287, 524287, 524287, 524287, 1'b1, '{19'sd0, 21'd0, 1'b1}},
		'{-1, -1, -1, -1, 1'b1, '{19'sd0, 21'd0, 1'b1}},
		'{0, 0, 7, 0, 1'b1, '{19'sd0, 21'd7, 1'b1}},
		'{0, 0, -7, 0, 1'b1, '{19'sd0, 21'd7, 1'b1}},
		'{0, 0, 0, -7, 1'b1, '{19'sd0, 21'd7, 1'b1}},
		'{100, 200, 104, 203, 1'b1, '{19'sd0, 21'd5, 1'b1}},
		'{0, 0, 5, 5, 1'b1, '{19'sd0, 21'd7, 1'b1}},
		'{0, 0, 8, 0, 1'b0, '0},
		'{0, 0, -8, 0, 1'b1, '{-19'sd205887, 21'd8, 1'b0}},
		'{524287, 0, -524288, 0, 1'b1, '{-19'sd205887, 21'd1048575, 1'b0}},
		'{-524288, 0, 524287, 0, 1'b0, '0},
		'{0, -524288, 0, 524287, 1'b0, '0},
		'{0, 524287, 0, -524288, 1'b0, '0},
		'{524287, 524287, -524288, -524288, 1'b0, '0},
		'{-524288, -524288, 524287, 524287, 1'b0, '0},
		'{524287, -524288, -524288, 524287, 1'b0, '0},
		'{0, 0, 1000, 1000, 1'b0, '0},
		'{0, 0, -1000, 1000, 1'b0, '0},
		'{0, 0, -1000, -1000, 1'b0, '0},
		'{0, 0, 1000, -1000, 1'b0, '0},
		'{0, 0, -524288, 1, 1'b0, '0},
		'{0, 0, -524288, -1, 1'b0, '0},
		'{0, 0, 6, 5, 1'b0, '0}
	};

	heading_and_distance uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.from_x     (from_x),
		.from_y     (from_y),
		.to_x       (to_x),
		.to_y       (to_y),
		.done       (done),
		.heading    (heading),
		.distance   (distance),
		.coincident (coincident),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// atan(2^-i) in units of 2^-32 rad: pi/4 for the first step, otherwise a
	// truncated power series in units of 2^-60 rad rounded half up.
	function automatic longint arctan_pow2(input int unsigned i);
		longint unsigned p;
		longint unsigned total;
		longint unsigned term;
		int unsigned k;
		if (i == 0) begin
			return ANGLE_QUARTER_PI;
		end
		p = 64'd1 << (60 - i);
		total = 0;
		k = 0;
		while (p != 0 && k < 64) begin
			term = p / longint'(2 * k + 1);
			if (k[0]) begin
				total = total - term;
			end else begin
				total = total + term;
			end
			p = p >> (2 * i);
			k++;
		end
		return longint'((total + (64'd1 << 27)) >> 28);
	endfunction

	// Integer square root, then rounded half up.
	function automatic longint unsigned rounded_root(input longint unsigned n);
		longint unsigned rt;
		longint unsigned bitv;
		longint unsigned rest;
		rt = 0;
		bitv = 64'd1 << 62;
		rest = n;
		while (bitv > rest) begin
			bitv = bitv >> 2;
		end
		while (bitv != 0) begin
			if (rest >= rt + bitv) begin
				rest = rest - (rt + bitv);
				rt = (rt >> 1) + bitv;
			end else begin
				rt = rt >> 1;
			end
			bitv = bitv >> 2;
		end
		if (n > rt * rt + rt) begin
			rt++;
		end
		return rt;
	endfunction

	// Vectoring rotation towards the x axis; the accumulated angle is the heading.
	function automatic longint bearing(input longint dx, input longint dy);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		int i;
		if (dy == 0 && dx < 0) begin
			return -HEADING_PI;
		end
		x = dx;
		y = dy;
		z = 0;
		// Left half plane: fold the vector over and start from +/-PI.
		if (dx < 0) begin
			x = -dx;
			y = -dy;
			z = (dy > 0) ? ANGLE_PI : -ANGLE_PI;
		end
		x = x * (64'sd1 << GUARD_BITS);
		y = y * (64'sd1 << GUARD_BITS);
		for (i = 0; i < ROT_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_step[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_step[i];
			end
		end
		z = (z + 64'sd32768) >>> 16;
		if (z > HEADING_PI - 1) begin
			z = HEADING_PI - 1;
		end
		if (z < -HEADING_PI) begin
			z = -HEADING_PI;
		end
		return z;
	endfunction

	// Heading and distance from one position to another under a given threshold.
	function automatic fix_t fix_between(input logic signed [IN_W-1:0] fx,
			input logic signed [IN_W-1:0] fy, input logic signed [IN_W-1:0] tx,
			input logic signed [IN_W-1:0] ty, input logic [THR_W-1:0] thr);
		longint dx;
		longint dy;
		longint unsigned span;
		fix_t r;
		dx = longint'(tx) - longint'(fx);
		dy = longint'(ty) - longint'(fy);
		span = rounded_root(longint'(dx * dx + dy * dy));
		r.distance = span[DIST_W-1:0];
		r.coincident = (span <= longint'(thr));
		r.heading = '0;
		if (!r.coincident) begin
			r.heading = HEAD_W'(bearing(dx, dy));
		end
		return r;
	endfunction

	// Appends one prediction behind those already waiting.
	function automatic void enqueue_fix(input fix_t f);
		fixes_in_flight = {fixes_in_flight, f};
	endfunction

	// Monitor: checks each result against the oldest prediction, tracks the threshold,
	// records a prediction for every item transfer and counts cycles without a transfer.
	always @(posedge clk) begin
		fix_t want;
		if (arst_n && done) begin
			if (fixes_in_flight.size() == 0) begin
				$error("result with nothing pending: heading %0d, distance %0d, coincident %0d",
					heading, distance, coincident);
				mismatches++;
			end else begin
				want = fixes_in_flight.pop_front();
				if (heading !== want.heading) begin
					$error("heading: expected %0d, got %0d", want.heading, heading);
					mismatches++;
				end
				if (distance !== want.distance) begin
					$error("distance: expected %0d, got %0d", want.distance, distance);
					mismatches++;
				end
				if (coincident !== want.coincident) begin
					$error("coincident: expected %0d, got %0d", want.coincident, coincident);
					mismatches++;
				end
			end
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			threshold_now = cfg_data;
		end
		if (arst_n && start && !busy) begin
			enqueue_fix(typed_valid ? typed_fix :
				fix_between(from_x, from_y, to_x, to_y, threshold_now));
		end
		if (arst_n && (done || (start && !busy) || (cfg_valid && cfg_ready))) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Watchdog: too long without any transfer means the block has hung.
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("testbench failed");
		$finish;
	end

	// Mostly short gaps with the odd long one, none at all in steady stretches.
	function automatic int pick_gap();
		int r;
		if (no_gaps) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 60);
	endfunction

	// Present one position pair and hold it until the transfer.
	task automatic send_pair(input int fx, input int fy, input int tx, input int ty,
			input bit typed, input fix_t fix);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		from_x      <= IN_W'(fx);
		from_y      <= IN_W'(fy);
		to_x        <= IN_W'(tx);
		to_y        <= IN_W'(ty);
		typed_valid <= typed;
		typed_fix   <= fix;
		do @(posedge clk); while (busy);
	endtask

	// Stop sending and let every result in flight come out.
	task automatic drain();
		start <= 1'b0;
		while (fixes_in_flight.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [THR_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic int rand_field();
		logic signed [IN_W-1:0] v;
		v = IN_W'($urandom);
		return int'(v);
	endfunction

	function automatic int corner_value();
		case ($urandom_range(0, 3))
			0: begin
				return IN_MIN;
			end
			1: begin
				return IN_MAX;
			end
			2: begin
				return 0;
			end
			default: begin
				return -1;
			end
		endcase
	endfunction

	// Moves a coordinate by d, or the other way if that would leave the field range.
	function automatic int shifted(input int base, input int d);
		if (base + d > IN_MAX || base + d < IN_MIN) begin
			return base - d;
		end
		return base + d;
	endfunction

	// Random pairs: fully random, close pairs around the threshold, pairs on an
	// axis, pairs near the negative x axis, corner values and exact boundaries.
	task automatic random_pairs(input int count, input int thr);
		int fx;
		int fy;
		int tx;
		int ty;
		int m;
		int d;
		int n;
		for (n = 0; n < count; n++) begin
			if (n % 64 == 0) begin
				no_gaps = ($urandom_range(0, 2) == 0);
			end
			fx = rand_field();
			fy = rand_field();
			tx = rand_field();
			ty = rand_field();
			case ($urandom_range(0, 9))
				4, 5: begin
					m = 2 * thr + 16;
					tx = shifted(fx, int'($urandom_range(0, 2 * m)) - m);
					ty = shifted(fy, int'($urandom_range(0, 2 * m)) - m);
				end
				6: begin
					if ($urandom_range(0, 1) == 0) begin
						tx = fx;
					end else begin
						ty = fy;
					end
				end
				7: begin
					tx = shifted(fx, -int'($urandom_range(1, 524288)));
					ty = shifted(fy, int'($urandom_range(0, 4)) - 2);
				end
				8: begin
					fx = corner_value();
					fy = corner_value();
					tx = corner_value();
					ty = corner_value();
				end
				9: begin
					d = thr + int'($urandom_range(0, 2)) - 1;
					if (d < 0) begin
						d = 0;
					end
					if ($urandom_range(0, 1) == 0) begin
						d = -d;
					end
					if ($urandom_range(0, 1) == 0) begin
						tx = shifted(fx, d);
						ty = fy;
					end else begin
						tx = fx;
						ty = shifted(fy, d);
					end
				end
				default: begin
				end
			endcase
			send_pair(fx, fy, tx, ty, 1'b0, '0);
		end
		no_gaps = 1'b0;
	endtask

	// Stimulus: reset, directed table under the reset threshold, then random
	// phases each under a threshold written while the block is idle.
	initial begin
		int i;
		int limits [PHASES];
		for (i = 0; i < ROT_STEPS; i++) begin
			atan_step[i] = arctan_pow2(i);
		end
		limits[0] = 0;
		limits[1] = 65535;
		limits[2] = $urandom_range(2, 300);
		limits[3] = 1;
		limits[4] = $urandom_range(0, 65535);
		limits[5] = 7;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < PROBES; i++) begin
			send_pair(probes[i].fx, probes[i].fy, probes[i].tx, probes[i].ty,
				probes[i].typed, probes[i].fix);
		end
		drain();

		for (i = 0; i < PHASES; i++) begin
			set_threshold(THR_W'(limits[i]));
			random_pairs(PHASE_ITEMS, limits[i]);
			drain();
		end

		if (mismatches == 0 && fixes_in_flight.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// ===== heading_and_distance.f =====
+incdir+hw/rtl
hw/rtl/hd_pkg.sv
hw/rtl/hd_front.sv
hw/rtl/hd_iter.sv
hw/rtl/hd_back.sv
hw/rtl/heading_and_distance.sv
dv/testbench.sv
